/* rtl/core/char_lcd_nibble_interface_defines.svh */
// Assertion macros shared by the character LCD nibble interface RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CLN_ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("cln assertion failed");
// Next-cycle implication.
`define CLN_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("cln assertion failed");
`else
`define CLN_ASSERT_IMPLIES(label, clock, resetn, ante, cons)
`define CLN_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif

`endif

/* rtl/core/cln_pkg.sv */
// Package for the character LCD nibble interface: field widths, request codes,
// the control word format and the microcode program. Depends on nothing.
package cln_pkg;

    localparam int REQ_W    = 4;
    localparam int LINE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int PIN_W    = 6;
    localparam int WAIT_W   = 16;
    localparam int NIB_W    = 4;
    localparam int FLAGS_W  = 4;

    localparam logic [BYTE_W-1:0] COLS_RESET = 8'd16;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_INIT       = 4'd0,
        REQ_CLEAR      = 4'd1,
        REQ_HOME       = 4'd2,
        REQ_DISP_ON    = 4'd3,
        REQ_DISP_OFF   = 4'd4,
        REQ_CURSOR_ON  = 4'd5,
        REQ_CURSOR_OFF = 4'd6,
        REQ_BLINK_ON   = 4'd7,
        REQ_BLINK_OFF  = 4'd8,
        REQ_SET_CURSOR = 4'd9,
        REQ_WRITE_BYTE = 4'd10,
        REQ_RAW_CMD    = 4'd11,
        REQ_RAW_DATA   = 4'd12
    } req_code_t;

    // Command bytes and flag bits.
    localparam logic [BYTE_W-1:0]  CMD_CLEAR    = 8'h01;
    localparam logic [BYTE_W-1:0]  CMD_HOME     = 8'h02;
    localparam logic [BYTE_W-1:0]  CMD_CONTROL  = 8'h08;
    localparam logic [BYTE_W-1:0]  DDRAM_LINE0  = 8'h80;
    localparam logic [BYTE_W-1:0]  DDRAM_LINE1  = 8'hC0;
    localparam logic [FLAGS_W-1:0] FLAG_VALID   = 4'h8;
    localparam logic [FLAGS_W-1:0] FLAG_DISPLAY = 4'h4;
    localparam logic [FLAGS_W-1:0] FLAG_CURSOR  = 4'h2;
    localparam logic [FLAGS_W-1:0] FLAG_BLINK   = 4'h1;

    // Where the nibble of a pin word comes from.
    typedef enum logic [1:0] {
        NS_CONST   = 2'd0,
        NS_BYTE_HI = 2'd1,
        NS_BYTE_LO = 2'd2,
        NS_CTRL_LO = 2'd3
    } nib_src_t;

    typedef enum logic [1:0] {
        RS_ZERO = 2'd0,
        RS_ONE  = 2'd1,
        RS_REQ  = 2'd2
    } rs_sel_t;

    typedef enum logic [2:0] {
        W_NONE  = 3'd0,
        W_40    = 3'd1,
        W_100   = 3'd2,
        W_1640  = 3'd3,
        W_4100  = 3'd4,
        W_40000 = 3'd5,
        W_REQ   = 3'd6
    } wait_sel_t;

    // One microcode step: produces one pin word.
    typedef struct packed {
        nib_src_t        nib_src;
        logic [NIB_W-1:0] nib;
        logic            en;
        rs_sel_t         rs_sel;
        wait_sel_t       wait_sel;
        logic            flags_on;  // set display and valid flags after this word
        logic            done;      // last word of the request, sequencer stops
    } ctrl_word_t;

    localparam int PROG_LEN   = 33;
    localparam int STEP_W     = $clog2(PROG_LEN);
    localparam logic [STEP_W-1:0] INIT_ENTRY = 6'd0;
    localparam logic [STEP_W-1:0] BYTE_ENTRY = 6'd29;
    localparam logic [STEP_W-1:0] LAST_STEP  = 6'd32;

    function automatic ctrl_word_t mk(nib_src_t src, logic [NIB_W-1:0] nib, logic en,
                                      rs_sel_t rs, wait_sel_t ws, logic fon, logic dn);
        ctrl_word_t w;
        w.nib_src  = src;
        w.nib      = nib;
        w.en       = en;
        w.rs_sel   = rs;
        w.wait_sel = ws;
        w.flags_on = fon;
        w.done     = dn;
        return w;
    endfunction

    // The microcode program. Init runs from step 0 to 28, every other
    // defined request runs the four-word byte routine at step 29.
    function automatic ctrl_word_t prog_rom(logic [STEP_W-1:0] step);
        ctrl_word_t w;
        case (step)
            // Reset word with a long power-up wait.
            6'd0:  w = mk(NS_CONST, 4'hF, 1'b1, RS_ONE,  W_40000, 1'b0, 1'b0);
            // Three nibbles of 3, then nibble 2 to enter 4-bit mode.
            6'd1:  w = mk(NS_CONST, 4'h3, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd2:  w = mk(NS_CONST, 4'h3, 1'b0, RS_ZERO, W_4100,  1'b0, 1'b0);
            6'd3:  w = mk(NS_CONST, 4'h3, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd4:  w = mk(NS_CONST, 4'h3, 1'b0, RS_ZERO, W_100,   1'b0, 1'b0);
            6'd5:  w = mk(NS_CONST, 4'h3, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd6:  w = mk(NS_CONST, 4'h3, 1'b0, RS_ZERO, W_40,    1'b0, 1'b0);
            6'd7:  w = mk(NS_CONST, 4'h2, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd8:  w = mk(NS_CONST, 4'h2, 1'b0, RS_ZERO, W_40,    1'b0, 1'b0);
            // Function set, two lines.
            6'd9:  w = mk(NS_CONST, 4'h2, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd10: w = mk(NS_CONST, 4'h2, 1'b0, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd11: w = mk(NS_CONST, 4'h8, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd12: w = mk(NS_CONST, 4'h8, 1'b0, RS_ZERO, W_40,    1'b0, 1'b0);
            // Display control with the display off.
            6'd13: w = mk(NS_CONST, 4'h0, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd14: w = mk(NS_CONST, 4'h0, 1'b0, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd15: w = mk(NS_CTRL_LO, 4'h0, 1'b1, RS_ZERO, W_NONE, 1'b0, 1'b0);
            6'd16: w = mk(NS_CTRL_LO, 4'h0, 1'b0, RS_ZERO, W_40,   1'b0, 1'b0);
            // Clear.
            6'd17: w = mk(NS_CONST, 4'h0, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd18: w = mk(NS_CONST, 4'h0, 1'b0, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd19: w = mk(NS_CONST, 4'h1, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd20: w = mk(NS_CONST, 4'h1, 1'b0, RS_ZERO, W_1640,  1'b0, 1'b0);
            // Entry mode, then turn the display flags on.
            6'd21: w = mk(NS_CONST, 4'h0, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd22: w = mk(NS_CONST, 4'h0, 1'b0, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd23: w = mk(NS_CONST, 4'h6, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd24: w = mk(NS_CONST, 4'h6, 1'b0, RS_ZERO, W_40,    1'b1, 1'b0);
            // Display control with the display on.
            6'd25: w = mk(NS_CONST, 4'h0, 1'b1, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd26: w = mk(NS_CONST, 4'h0, 1'b0, RS_ZERO, W_NONE,  1'b0, 1'b0);
            6'd27: w = mk(NS_CTRL_LO, 4'h0, 1'b1, RS_ZERO, W_NONE, 1'b0, 1'b0);
            6'd28: w = mk(NS_CTRL_LO, 4'h0, 1'b0, RS_ZERO, W_40,   1'b0, 1'b1);
            // Byte routine for all single-byte requests.
            6'd29: w = mk(NS_BYTE_HI, 4'h0, 1'b1, RS_REQ, W_NONE,  1'b0, 1'b0);
            6'd30: w = mk(NS_BYTE_HI, 4'h0, 1'b0, RS_REQ, W_NONE,  1'b0, 1'b0);
            6'd31: w = mk(NS_BYTE_LO, 4'h0, 1'b1, RS_REQ, W_NONE,  1'b0, 1'b0);
            6'd32: w = mk(NS_BYTE_LO, 4'h0, 1'b0, RS_REQ, W_REQ,   1'b0, 1'b1);
            default: w = mk(NS_CONST, 4'h0, 1'b0, RS_ZERO, W_NONE, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [WAIT_W-1:0] wait_value(wait_sel_t sel);
        logic [WAIT_W-1:0] v;
        case (sel)
            W_40:    v = 16'd40;
            W_100:   v = 16'd100;
            W_1640:  v = 16'd1640;
            W_4100:  v = 16'd4100;
            W_40000: v = 16'd40000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/cln_ifs.sv */
// Handshake channel interfaces for the character LCD nibble interface.
// Depends on cln_pkg for the field widths.
interface cln_req_if;
    logic                          valid;
    logic                          ready;
    logic [cln_pkg::REQ_W-1:0]     req_type;
    logic [cln_pkg::LINE_W-1:0]    line;
    logic [cln_pkg::BYTE_W-1:0]    column;
    logic [cln_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, req_type, line, column, data_byte, input ready);
    modport sink   (input valid, req_type, line, column, data_byte, output ready);
endinterface

interface cln_pin_if;
    logic                          valid;
    logic                          ready;
    logic [cln_pkg::PIN_W-1:0]     pin_word;
    logic [cln_pkg::WAIT_W-1:0]    wait_us;
    logic                          last;

    modport source (output valid, pin_word, wait_us, last, input ready);
    modport sink   (input valid, pin_word, wait_us, last, output ready);
endinterface

interface cln_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cln_pkg::BYTE_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/char_lcd_nibble_interface.sv */
// Character LCD nibble interface: turns requests into pin words for a
// 4-bit display bus. Depends on cln_pkg, cln_ifs and the defines header.
//
// Usage. Requests arrive on the req channel (req_type, line, column,
// data_byte). Each accepted request becomes a run of pin words on the pins
// channel: pin_word holds the data nibble in bits 3-0, RS in bit 4 and E in
// bit 5, wait_us is the delay the bus driver must insert after the word, and
// last marks the final word of the request. The cfg channel, always ready,
// writes the columns-per-line register (reset 16) used by set cursor for
// lines 2 and 3; the user must write it only while idle (not enforced).
//
// Timing. A microcode sequencer emits one pin word per cycle while the
// receiver takes them: four words for a single-byte request, twenty-nine
// for init, each word loaded into the output register. A new request is
// taken as soon as the last word has been loaded, even while that word
// still waits in the output register. Unused request codes are taken and
// produce nothing.
//
// Reset clears the display flags, the sequencer and the output valid. When
// the receiver holds ready low the output word holds and the sequencer waits.
`include "char_lcd_nibble_interface_defines.svh"

module char_lcd_nibble_interface (
    input  logic      clk,
    input  logic      rst_n,
    cln_req_if.sink   req,
    cln_pin_if.source pins,
    cln_cfg_if.sink   cfg
);
    import cln_pkg::*;

    // Sequencer and request registers.
    logic                busy_reg,     busy_next;
    logic [STEP_W-1:0]   step_reg,     step_next;
    logic [FLAGS_W-1:0]  flags_reg,    flags_next;
    logic [BYTE_W-1:0]   byte_reg,     byte_next;
    logic                rs_reg,       rs_next;
    wait_sel_t           req_wait_reg, req_wait_next;
    logic [BYTE_W-1:0]   cols_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]    pin_reg;
    logic [WAIT_W-1:0]   wait_reg;
    logic                last_reg;

    logic                req_fire;
    logic                out_load;
    ctrl_word_t          cw;
    logic [NIB_W-1:0]    nib;
    logic                rs_bit;
    wait_sel_t           wait_sel;

    // Request decode values.
    logic                start;
    logic [STEP_W-1:0]   start_step;
    logic [BYTE_W-1:0]   req_byte;
    logic                req_rs;
    wait_sel_t           req_wait;
    logic [FLAGS_W-1:0]  req_flags;
    logic [BYTE_W-1:0]   addr_sum;
    logic [BYTE_W-1:0]   addr;

    assign req.ready  = !busy_reg;
    assign cfg.ready  = 1'b1;
    assign req_fire   = req.valid && req.ready;

    // The sequencer runs whenever the output register is free or drains.
    assign out_load   = busy_reg && (!out_valid_reg || pins.ready);

    assign pins.valid    = out_valid_reg;
    assign pins.pin_word = pin_reg;
    assign pins.wait_us  = wait_reg;
    assign pins.last     = last_reg;

    // Set-cursor address: lines two and three are offset by the line width,
    // wrapping within a byte; odd lines live in the second DDRAM half.
    always_comb
    begin
        if (req.line == 3'd2 || req.line == 3'd3)
            addr_sum = req.column + cols_reg;
        else
            addr_sum = req.column;
        if (req.line == 3'd1 || req.line == 3'd3)
            addr = addr_sum | DDRAM_LINE1;
        else
            addr = addr_sum | DDRAM_LINE0;
    end

    // Request decode. Single-byte requests load the byte, RS and final wait
    // and jump into the byte routine; init jumps to the start of the program.
    always_comb
    begin
        start      = 1'b1;
        start_step = BYTE_ENTRY;
        req_byte   = req.data_byte;
        req_rs     = 1'b0;
        req_wait   = W_40;
        req_flags  = flags_reg;
        case (req.req_type)
            REQ_INIT:
            begin
                start_step = INIT_ENTRY;
                req_flags  = '0;
            end
            REQ_CLEAR:
            begin
                req_byte = CMD_CLEAR;
                req_wait = W_1640;
            end
            REQ_HOME:
            begin
                req_byte = CMD_HOME;
                req_wait = W_1640;
            end
            REQ_DISP_ON, REQ_CURSOR_ON, REQ_BLINK_ON:
            begin
                if (req.req_type == REQ_DISP_ON)
                    req_flags = flags_reg | FLAG_VALID | FLAG_DISPLAY;
                else if (req.req_type == REQ_CURSOR_ON)
                    req_flags = flags_reg | FLAG_VALID | FLAG_CURSOR;
                else
                    req_flags = flags_reg | FLAG_VALID | FLAG_BLINK;
                req_byte = CMD_CONTROL | {5'd0, req_flags[2:0]};
            end
            REQ_DISP_OFF, REQ_CURSOR_OFF, REQ_BLINK_OFF:
            begin
                if (req.req_type == REQ_DISP_OFF)
                    req_flags = flags_reg & ~FLAG_DISPLAY;
                else if (req.req_type == REQ_CURSOR_OFF)
                    req_flags = flags_reg & ~FLAG_CURSOR;
                else
                    req_flags = flags_reg & ~FLAG_BLINK;
                req_byte = CMD_CONTROL | {5'd0, req_flags[2:0]};
            end
            REQ_SET_CURSOR:
            begin
                req_byte = addr;
            end
            REQ_WRITE_BYTE:
            begin
                req_rs = 1'b1;
            end
            REQ_RAW_CMD:
            begin
                req_wait = W_NONE;
            end
            REQ_RAW_DATA:
            begin
                req_rs   = 1'b1;
                req_wait = W_NONE;
            end
            default:
            begin
                // Unused codes are consumed without any output.
                start = 1'b0;
            end
        endcase
    end

    // Datapath driven by the current control word.
    always_comb
    begin
        cw = prog_rom(step_reg);
        case (cw.nib_src)
            NS_BYTE_HI: nib = byte_reg[7:4];
            NS_BYTE_LO: nib = byte_reg[3:0];
            NS_CTRL_LO: nib = CMD_CONTROL[3:0] | {1'b0, flags_reg[2:0]};
            default:    nib = cw.nib;
        endcase
        case (cw.rs_sel)
            RS_ONE:  rs_bit = 1'b1;
            RS_REQ:  rs_bit = rs_reg;
            default: rs_bit = 1'b0;
        endcase
        if (cw.wait_sel == W_REQ)
            wait_sel = req_wait_reg;
        else
            wait_sel = cw.wait_sel;
    end

    // Next-state logic. A request is taken only while idle and the
    // sequencer only advances while busy, so the two never collide.
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        flags_next     = flags_reg;
        byte_next      = byte_reg;
        rs_next        = rs_reg;
        req_wait_next  = req_wait_reg;
        out_valid_next = out_valid_reg;
        if (pins.ready)
            out_valid_next = 1'b0;
        if (req_fire)
        begin
            busy_next     = start;
            step_next     = start_step;
            flags_next    = req_flags;
            byte_next     = req_byte;
            rs_next       = req_rs;
            req_wait_next = req_wait;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            step_next      = step_reg + 1'b1;
            if (cw.flags_on)
                flags_next = flags_reg | FLAG_VALID | FLAG_DISPLAY;
            if (cw.done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
            cols_reg      <= COLS_RESET;
            rs_reg        <= 1'b0;
            req_wait_reg  <= W_NONE;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
            rs_reg        <= rs_next;
            req_wait_reg  <= req_wait_next;
            if (cfg.valid && cfg.ready)
                cols_reg <= cfg.data;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (out_load)
        begin
            pin_reg  <= {cw.en, rs_bit, nib};
            wait_reg <= wait_value(wait_sel);
            last_reg <= cw.done;
        end
    end

    // The step counter never leaves the program while running.
    `CLN_ASSERT_IMPLIES(a_step_in_prog, clk, rst_n, busy_reg, step_reg <= LAST_STEP)
    // Loading the final word of a program frees the sequencer.
    `CLN_ASSERT_NEXT(a_done_idles, clk, rst_n, out_load && cw.done, !busy_reg && last_reg)
    // The final word of a request always leaves E low.
    `CLN_ASSERT_IMPLIES(a_last_e_low, clk, rst_n, pins.valid && pins.last, !pins.pin_word[5])
    // Init starts the program at its first step.
    `CLN_ASSERT_NEXT(a_init_entry, clk, rst_n, req_fire && req.req_type == REQ_INIT,
                     busy_reg && step_reg == INIT_ENTRY)

endmodule
